// File: hdl/mdfr_pkg.sv
// Shared types and constants of the multi-datagram frame reassembler.
package mdfr_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_MAGIC      = 2'd0;
  localparam logic [1:0] REG_CHUNK      = 2'd1;
  localparam logic [1:0] REG_DGRAMS     = 2'd2;
  localparam logic [1:0] REG_LAST_CHUNK = 2'd3;

  localparam logic [7:0]  RST_MAGIC      = 8'h3E;
  localparam logic [15:0] RST_CHUNK      = 16'(62 * 1024);
  localparam logic [8:0]  RST_DGRAMS     = 9'd1;
  localparam logic [15:0] RST_LAST_CHUNK = 16'd0;

  typedef struct packed {
    logic [7:0]  magic_byte;
    logic [15:0] chunk_bytes;
    logic [8:0]  datagrams_per_frame;
    logic [15:0] last_chunk_bytes;
  } cfg_t;

endpackage

// File: hdl/mdfr_regs.sv
// APB configuration registers of the frame reassembler.
module mdfr_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mdfr_pkg::ADDR_W-1:0] paddr,
  input  logic [mdfr_pkg::DATA_W-1:0] pwdata,
  output logic [mdfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output mdfr_pkg::cfg_t             cfg_o
);
  import mdfr_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_byte          <= RST_MAGIC;
      cfg_q.chunk_bytes         <= RST_CHUNK;
      cfg_q.datagrams_per_frame <= RST_DGRAMS;
      cfg_q.last_chunk_bytes    <= RST_LAST_CHUNK;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAGIC:      cfg_q.magic_byte          <= pwdata[7:0];
        REG_CHUNK:      cfg_q.chunk_bytes         <= pwdata[15:0];
        REG_DGRAMS:     cfg_q.datagrams_per_frame <= pwdata[8:0];
        REG_LAST_CHUNK: cfg_q.last_chunk_bytes    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAGIC:      prdata = DATA_W'(cfg_q.magic_byte);
      REG_CHUNK:      prdata = DATA_W'(cfg_q.chunk_bytes);
      REG_DGRAMS:     prdata = DATA_W'(cfg_q.datagrams_per_frame);
      REG_LAST_CHUNK: prdata = DATA_W'(cfg_q.last_chunk_bytes);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hdl/multi_datagram_frame_reassembler.sv
// Top level of the multi-datagram frame reassembler.
// Usage:
//   Slave stream: one datagram byte per item in s_axis_tdata, s_axis_tuser marks
//   the first byte of a datagram, s_axis_tlast the last one.
//   Master stream: one item per payload byte or frame event. tdata carries the
//   byte and its frame offset, tuser the payload-valid and abort flags, tlast
//   marks the end of the final datagram of a frame (frame done).
//   APB port: magic byte, chunk length, datagrams per frame, last chunk length.
//   Write registers only while the stream is idle.
// Path: an item accepted into the input register gives its result in the output
//   register once that register is free. Throughput: one item per cycle while
//   no result waits on a stalled receiver; the header check, position count and
//   offset update for an item are combinational around a single 8x16 multiplier.
// Items that give no result (headers, stray or excess bytes) are consumed
//   without output.
// Reset clears both stages and puts the block in hunt mode with the register
//   defaults. When the receiver stalls, the result is held in the output
//   register and the input stage keeps taking items until it holds one that
//   has a result to deliver; then s_axis_tready drops.
module multi_datagram_frame_reassembler #(
  parameter int MAX_DATAGRAMS = 256,
  parameter int OFFSET_BITS   = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                  s_axis_tuser,  // [0] dgram_first
  input  logic                        s_axis_tlast,  // dgram_last
  // master stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,  // [7:0] payload_byte, [31:8] frame_offset
  output logic [1:0]                  m_axis_tuser,  // [0] payload_valid, [1] frame_abort
  output logic                        m_axis_tlast,  // frame_done
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mdfr_pkg::ADDR_W-1:0] paddr,
  input  logic [mdfr_pkg::DATA_W-1:0] pwdata,
  output logic [mdfr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mdfr_pkg::*;

  localparam logic       MODE_HUNT = 1'b0;
  localparam logic       MODE_SYNC = 1'b1;
  localparam logic [15:0] POS_SAT  = 16'hFFFF;
  localparam logic [8:0]  MAX_DG   = 9'(MAX_DATAGRAMS);

  cfg_t cfg;

  mdfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       in_last_q;

  // output stage
  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_last_q;

  // frame state
  logic                   sync_q, sync_d;
  logic [7:0]             exp_q, exp_d;
  logic [15:0]            pos_q, pos_d;
  logic                   hg_q, hg_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic                   rej_q, rej_d;

  logic [8:0]             n_cl;
  logic [7:0]             fin;
  logic                   rej_c, hg_c;
  logic [15:0]            pos_c, q, limit;
  logic [7:0]             want;
  logic [23:0]            prod;
  logic                   bad, pv, done, abrt, res_hit;
  logic [7:0]             ob;
  logic [OFFSET_BITS-1:0] offs;
  logic                   out_free, adv;

  always_comb begin
    n_cl = (cfg.datagrams_per_frame == 9'd0) ? 9'd1 : cfg.datagrams_per_frame;
    if (n_cl > MAX_DG) n_cl = MAX_DG;
    fin = 8'(n_cl - 9'd1);
  end

  always_comb begin
    rej_c  = !in_first_q && rej_q;
    pos_c  = in_first_q ? 16'd0 : pos_q;
    hg_c   = !in_first_q && hg_q;
    sync_d = sync_q;
    exp_d  = exp_q;
    pos_d  = pos_c;
    hg_d   = hg_c;
    off_d  = off_q;
    rej_d  = rej_c;
    bad    = 1'b0;
    pv     = 1'b0;
    done   = 1'b0;
    abrt   = 1'b0;
    ob     = 8'd0;
    offs   = '0;
    q      = pos_c - 16'd2;
    limit  = (exp_q == fin) ? cfg.last_chunk_bytes : cfg.chunk_bytes;
    want   = (sync_q == MODE_SYNC) ? exp_q : 8'd0;
    prod   = 24'(want) * 24'(cfg.chunk_bytes);
    if (!rej_c) begin
      if (pos_c != POS_SAT) pos_d = pos_c + 16'd1;
      if (pos_c == 16'd0) begin
        if (in_byte_q == cfg.magic_byte) hg_d = 1'b1;
        else bad = 1'b1;
        if (in_last_q) bad = 1'b1;
      end else if (pos_c == 16'd1) begin
        if (hg_c && in_byte_q == want) begin
          if (sync_q != MODE_SYNC) begin
            sync_d = MODE_SYNC;
            exp_d  = 8'd0;
          end
          off_d = OFFSET_BITS'(prod);
        end else begin
          bad = 1'b1;
        end
      end else if (pos_c != POS_SAT && q < limit) begin
        pv   = 1'b1;
        ob   = in_byte_q;
        offs = off_q + OFFSET_BITS'(q);
      end
      if (bad) begin
        abrt   = (sync_q == MODE_SYNC);
        sync_d = MODE_HUNT;
        exp_d  = 8'd0;
        hg_d   = 1'b0;
        rej_d  = 1'b1;
      end else if (in_last_q) begin
        if (exp_d == fin) begin
          done  = 1'b1;
          exp_d = 8'd0;
        end else begin
          exp_d = exp_d + 8'd1;
        end
        rej_d = 1'b1;
      end
    end
    res_hit = pv || done || abrt;
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign adv           = in_valid_q && (!res_hit || out_free);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_first_q <= 1'b0;
      in_last_q  <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
      in_first_q <= s_axis_tuser[0];
      in_last_q  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) in_byte_q <= s_axis_tdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= MODE_HUNT;
      exp_q  <= 8'd0;
      pos_q  <= 16'd0;
      hg_q   <= 1'b0;
      off_q  <= '0;
      rej_q  <= 1'b0;
    end else if (adv) begin
      sync_q <= sync_d;
      exp_q  <= exp_d;
      pos_q  <= pos_d;
      hg_q   <= hg_d;
      off_q  <= off_d;
      rej_q  <= rej_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && res_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && adv && res_hit) begin
      out_data_q <= {24'(offs), ob};
      out_user_q <= {abrt, pv};
      out_last_q <= done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: hdl/mdfr_checker.sv
// Port checker of the frame reassembler and its bind.
module mdfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // nothing leaves the block while reset is held
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output item during reset");

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output item changed");

  // every item carries a payload byte, a frame end or an abort
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tuser[1] || m_axis_tlast)
    else $error("output item with no flag");

  // an abort stands alone, and without payload the data field is clear
  a_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && !m_axis_tlast &&
      m_axis_tdata == 32'd0)
    else $error("abort item carries payload or frame end");

endmodule

bind multi_datagram_frame_reassembler mdfr_checker u_mdfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/multi_datagram_frame_reassembler_tb.sv
// Self-checking testbench for the multi-datagram frame reassembler.
`timescale 1ns / 1ps

module multi_datagram_frame_reassembler_tb;
  import mdfr_pkg::*;

  localparam int MAX_DG = 256;

  typedef enum logic {MODE_HUNT, MODE_SYNC} sync_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic [23:0] off;
    logic        done;
    logic        abrt;
  } frame_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  multi_datagram_frame_reassembler dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  cfg_t        cfg;
  sync_e       mode;
  logic [7:0]  exp_idx;
  logic [15:0] pos;
  logic        hdr_ok;
  logic [23:0] base_off;
  logic        rejected;

  frame_item_t frame_q[$];
  frame_item_t got, want_item;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int frames_seen = 0;
  int aborts_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;

  function automatic logic [7:0] final_index();
    logic [8:0] n;
    n = cfg.datagrams_per_frame;
    if (n == 9'd0) n = 9'd1;
    if (n > 9'(MAX_DG)) n = 9'(MAX_DG);
    return 8'(n - 9'd1);
  endfunction

  task automatic reassemble_byte(input logic [7:0] b, input logic first, input logic last);
    logic [15:0] p, q, limit;
    logic [7:0]  want, fin;
    logic        bad;
    frame_item_t e;
    fin = final_index();
    bad = 1'b0;
    e = '0;
    if (first) begin
      pos = '0;
      rejected = 1'b0;
      hdr_ok = 1'b0;
    end
    if (rejected) return;
    p = pos;
    if (pos != 16'hFFFF) pos = pos + 16'd1;
    if (p == 16'd0) begin
      if (b == cfg.magic_byte) hdr_ok = 1'b1;
      else bad = 1'b1;
      if (last) bad = 1'b1;
    end else if (p == 16'd1) begin
      want = (mode == MODE_SYNC) ? exp_idx : 8'd0;
      if (hdr_ok && b == want) begin
        if (mode != MODE_SYNC) begin
          mode = MODE_SYNC;
          exp_idx = 8'd0;
        end
        base_off = 24'(exp_idx) * 24'(cfg.chunk_bytes);
      end else begin
        bad = 1'b1;
      end
    end else begin
      q = p - 16'd2;
      limit = (exp_idx == fin) ? cfg.last_chunk_bytes : cfg.chunk_bytes;
      if (p != 16'hFFFF && q < limit) begin
        e.valid = 1'b1;
        e.data = b;
        e.off = base_off + 24'(q);
      end
    end
    if (bad) begin
      if (mode == MODE_SYNC) e.abrt = 1'b1;
      mode = MODE_HUNT;
      exp_idx = 8'd0;
      hdr_ok = 1'b0;
      rejected = 1'b1;
    end else if (last) begin
      if (exp_idx == fin) begin
        e.done = 1'b1;
        exp_idx = 8'd0;
      end else begin
        exp_idx = exp_idx + 8'd1;
      end
      rejected = 1'b1;
    end
    if (e.valid || e.done || e.abrt) frame_q.push_back(e);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[31:8],
              m_axis_tlast, m_axis_tuser[1]};
      results_seen++;
      if (got.done) frames_seen++;
      if (got.abrt) aborts_seen++;
      if (frame_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: valid %0b byte %02h off %06h done %0b abort %0b",
                   got.valid, got.data, got.off, got.done, got.abrt);
      end else begin
        want_item = frame_q.pop_front();
        if (got !== want_item) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0b %02h %06h %0b %0b, got %0b %02h %06h %0b %0b",
                     want_item.valid, want_item.data, want_item.off,
                     want_item.done, want_item.abrt,
                     got.valid, got.data, got.off, got.done, got.abrt);
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic set_idle(input idle_e m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 68; recv_idle_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_idle_pct = 68; end
      default:   begin send_idle_pct = 16; recv_idle_pct = 16; end
    endcase
  endtask

  task automatic send_item(input logic [7:0] b, input logic first, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    reassemble_byte(b, first, last);
    items_sent++;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_dgram(input logic [7:0] m, input logic [7:0] idx, input int npay,
                            input bit close);
    int i;
    send_item(m, 1'b1, 1'b0);
    send_item(idx, 1'b0, close && npay == 0);
    for (i = 0; i < npay; i++)
      send_item(8'($urandom_range(255)), 1'b0, close && i == npay - 1);
  endtask

  // wait for every expected result, then let the pipeline empty
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // write one register, then read it back
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd_exp;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAGIC: begin
        cfg.magic_byte = val[7:0];
        rd_exp = 32'(val[7:0]);
      end
      REG_CHUNK: begin
        cfg.chunk_bytes = val[15:0];
        rd_exp = 32'(val[15:0]);
      end
      REG_DGRAMS: begin
        cfg.datagrams_per_frame = val[8:0];
        rd_exp = 32'(val[8:0]);
      end
      default: begin
        cfg.last_chunk_bytes = val[15:0];
        rd_exp = 32'(val[15:0]);
      end
    endcase
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== rd_exp) begin
      errors++;
      if (errors <= 10)
        $display("register %0d read back: exp %08h got %08h", idx, rd_exp, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [7:0] m, input logic [15:0] chunk,
                           input logic [8:0] n, input logic [15:0] last_len);
    reg_write(REG_MAGIC, 32'(m));
    reg_write(REG_CHUNK, 32'(chunk));
    reg_write(REG_DGRAMS, 32'(n));
    reg_write(REG_LAST_CHUNK, 32'(last_len));
  endtask

  // defaults; first byte after reset opens a datagram even without a first mark
  task automatic test_after_reset();
    send_item(RST_MAGIC, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'hAA, 1'b0, 1'b1);
    send_dgram(RST_MAGIC, 8'h00, 0, 1'b1);
    wait_quiet();
  endtask

  task automatic test_header_faults();
    write_all(8'hFF, 16'd2, 9'd2, 16'd1);
    send_item(8'h11, 1'b0, 1'b0);          // stray byte
    send_dgram(8'hFF, 8'h00, 2, 1'b1);
    send_dgram(8'hFF, 8'h01, 2, 1'b1);     // final, one byte dropped
    send_dgram(8'hFE, 8'h00, 1, 1'b1);     // bad magic in sync
    send_dgram(8'hFF, 8'h01, 1, 1'b1);     // hunting, ignored
    send_dgram(8'hFF, 8'h00, 3, 1'b1);     // excess byte
    send_dgram(8'hFF, 8'h01, 1, 1'b0);     // cut off
    send_dgram(8'hFF, 8'h01, 1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);          // short datagram
    wait_quiet();
  endtask

  task automatic test_zero_chunk();
    write_all(8'h00, 16'd0, 9'd2, 16'd3);
    send_dgram(8'h00, 8'h00, 1, 1'b1);
    send_dgram(8'h00, 8'h01, 4, 1'b1);
    wait_quiet();
    reg_write(REG_DGRAMS, 32'd0);
    send_dgram(8'h00, 8'h00, 2, 1'b1);
    wait_quiet();
  endtask

  // every index value, largest offsets
  task automatic test_deep_frame();
    int k;
    set_idle(IDLE_BOTH);
    write_all(8'($urandom_range(255)), 16'hFFFF, 9'h1FF, 16'd4);
    for (k = 0; k < 255; k++) send_dgram(cfg.magic_byte, 8'(k), 0, 1'b1);
    send_dgram(cfg.magic_byte, 8'hFF, 5, 1'b1);
    wait_quiet();
  endtask

  task automatic test_backpressure();
    set_idle(IDLE_NONE);
    write_all(8'h5A, 16'd7, 9'd1, 16'd100);
    hold_len = 300;
    send_dgram(8'h5A, 8'h00, 80, 1'b1);
    wait_quiet();
  endtask

  task automatic random_settings();
    logic [7:0]  m;
    logic [15:0] chunk, last_len;
    logic [8:0]  n;
    case ($urandom_range(3))
      0: m = 8'h00;
      1: m = 8'hFF;
      2: m = RST_MAGIC;
      default: m = 8'($urandom_range(255));
    endcase
    case ($urandom_range(6))
      0: chunk = 16'd0;
      1: chunk = 16'd1;
      2: chunk = 16'hFFFF;
      3: chunk = 16'($urandom_range(65535));
      default: chunk = 16'($urandom_range(2, 6));
    endcase
    case ($urandom_range(4))
      0: n = 9'd0;
      1: n = 9'd1;
      default: n = 9'($urandom_range(2, 6));
    endcase
    case ($urandom_range(4))
      0: last_len = 16'd0;
      1: last_len = 16'hFFFF;
      default: last_len = 16'($urandom_range(1, 8));
    endcase
    write_all(m, chunk, n, last_len);
  endtask

  // mostly well-formed frames, some faults and noise
  task automatic random_frame();
    logic [7:0] fin, idx, m;
    int k, kind, npay, lim;
    fin = final_index();
    for (k = 0; k <= int'(fin); k++) begin
      kind = $urandom_range(99);
      lim = (k == int'(fin)) ? int'(cfg.last_chunk_bytes) : int'(cfg.chunk_bytes);
      npay = (lim > 10) ? $urandom_range(10) : lim;
      if ($urandom_range(9) == 0) npay += $urandom_range(1, 3);
      m = cfg.magic_byte;
      idx = 8'(k);
      if (kind >= 95)
        repeat ($urandom_range(1, 3))
          send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (kind < 6) m = m ^ 8'($urandom_range(1, 255));
      else if (kind < 11) idx = idx ^ 8'($urandom_range(1, 255));
      if (kind >= 11 && kind < 14) begin
        send_item(m, 1'b1, 1'b1);
        break;
      end
      send_dgram(m, idx, npay, !(kind >= 14 && kind < 17));
      if (kind < 17) break;
    end
  endtask

  task automatic test_random_traffic();
    int i, s, target;
    for (i = 0; i < 4; i++) begin
      set_idle(idle_e'(i));
      for (s = 0; s < 3; s++) begin
        random_settings();
        target = items_sent + 52;
        while (items_sent < target) random_frame();
        wait_quiet();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg = '{RST_MAGIC, RST_CHUNK, RST_DGRAMS, RST_LAST_CHUNK};
    mode = MODE_HUNT;
    exp_idx = '0;
    pos = '0;
    hdr_ok = 1'b0;
    base_off = '0;
    rejected = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_header_faults();
    test_zero_chunk();
    test_backpressure();
    test_deep_frame();
    test_random_traffic();

    wait_quiet();
    repeat (10) @(posedge clk_i);
    $display("covered %0d input items over 12 random settings and all idle phases",
             items_sent);
    $display("checked %0d results, %0d frames completed, %0d aborts, %0d errors",
             results_seen, frames_seen, aborts_seen, errors);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: multi_datagram_frame_reassembler.f
hdl/mdfr_pkg.sv
hdl/mdfr_regs.sv
hdl/multi_datagram_frame_reassembler.sv
hdl/mdfr_checker.sv
tb/multi_datagram_frame_reassembler_tb.sv
